/* design/ccs_pkg.sv */
// types and constants shared by the curvature command smoother
`default_nettype none

package ccs_pkg;

	// configuration port geometry
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 17;

	// register field widths
	localparam int LIMIT_WIDTH = 15;
	localparam int GAIN_WIDTH  = 17;
	localparam int STEP_WIDTH  = 16;

	// register indexes on the configuration port
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_TRACKING_LIMIT     = 3'd0,
		REG_INVERSE_MIN_RADIUS = 3'd1,
		REG_DEADBAND           = 3'd2,
		REG_FILTER_GAIN        = 3'd3,
		REG_MAX_STEP           = 3'd4
	} reg_idx_t;

	// reset values of the registers
	localparam logic [LIMIT_WIDTH-1:0] TRACKING_LIMIT_RST     = 15'd7782;
	localparam logic [LIMIT_WIDTH-1:0] INVERSE_MIN_RADIUS_RST = 15'd8605;
	localparam logic [LIMIT_WIDTH-1:0] DEADBAND_RST           = 15'd82;
	localparam logic [GAIN_WIDTH-1:0]  FILTER_GAIN_RST        = 17'd18725;
	localparam logic [STEP_WIDTH-1:0]  MAX_STEP_RST           = 16'd614;

	// register set as seen by the datapath
	typedef struct packed {
		logic [LIMIT_WIDTH-1:0] tracking_limit;
		logic [LIMIT_WIDTH-1:0] inverse_min_radius;
		logic [LIMIT_WIDTH-1:0] deadband;
		logic [GAIN_WIDTH-1:0]  filter_gain;
		logic [STEP_WIDTH-1:0]  max_step;
	} cfg_t;

endpackage

`default_nettype wire

/* design/ccs_datapath.sv */
// one smoothing update: clamp, deadband, low-pass, rate limit, saturate
`default_nettype none

module ccs_datapath #(
	parameter int DATA_WIDTH         = 16,
	parameter int GAIN_FRACTION_BITS = 16
) (
	input  wire ccs_pkg::cfg_t                   cfg,
	input  wire logic signed [DATA_WIDTH-1:0]    target,
	input  wire logic                            restart,
	input  wire logic signed [DATA_WIDTH-1:0]    last,
	output logic signed [DATA_WIDTH-1:0]         next
);

	// working width covers data range, 17 bit registers and a difference
	localparam int BASE_W = (DATA_WIDTH > ccs_pkg::GAIN_WIDTH) ? DATA_WIDTH
	                                                          : ccs_pkg::GAIN_WIDTH;
	localparam int CW     = BASE_W + 2;
	localparam int GBASE  = ((GAIN_FRACTION_BITS + 1) > ccs_pkg::GAIN_WIDTH) ?
	                        (GAIN_FRACTION_BITS + 1) : ccs_pkg::GAIN_WIDTH;
	localparam int GW     = GBASE + 1;
	localparam int PW     = CW + GW;

	localparam logic signed [GW-1:0] GAIN_ONE = GW'(64'd1 << GAIN_FRACTION_BITS);
	localparam logic signed [PW-1:0] HALF     = PW'(64'd1 << (GAIN_FRACTION_BITS - 1));
	localparam logic signed [CW:0]   DMAX     = {{(CW - DATA_WIDTH + 2){1'b0}},
	                                             {(DATA_WIDTH - 1){1'b1}}};
	localparam logic signed [CW:0]   DMIN     = ~DMAX;

	logic [ccs_pkg::LIMIT_WIDTH-1:0] lim;
	logic signed [CW-1:0] t_x, last_x, lim_x, t_cl, diff1, mag, db_x, t_db, diff2;
	logic signed [CW-1:0] ms_x, step_c, step_l;
	logic signed [GW-1:0] gain_x, gain_s;
	logic signed [PW-1:0] prod, rnd, step_full;
	logic signed [CW:0]   sum;

	always_comb begin
		// restart zeroes the stored curvature first
		last_x = restart ? '0 : {{(CW - DATA_WIDTH){last[DATA_WIDTH-1]}}, last};
		t_x    = {{(CW - DATA_WIDTH){target[DATA_WIDTH-1]}}, target};

		// effective limit, zero means no clamp
		lim = cfg.tracking_limit;
		if (cfg.inverse_min_radius != '0) begin
			lim = (cfg.tracking_limit != '0 && cfg.tracking_limit < cfg.inverse_min_radius)
			      ? cfg.tracking_limit : cfg.inverse_min_radius;
		end
		lim_x = CW'(lim);

		t_cl = t_x;
		if (lim != '0) begin
			if (t_x < -lim_x) begin
				t_cl = -lim_x;
			end else if (t_x > lim_x) begin
				t_cl = lim_x;
			end
		end

		// small changes keep the previous curvature
		diff1 = t_cl - last_x;
		mag   = (diff1 < 0) ? -diff1 : diff1;
		db_x  = CW'(cfg.deadband);
		t_db  = (mag < db_x) ? last_x : t_cl;

		// first-order low-pass, round half up
		gain_x    = GW'(cfg.filter_gain);
		gain_s    = (gain_x > GAIN_ONE) ? GAIN_ONE : gain_x;
		diff2     = t_db - last_x;
		prod      = PW'(gain_s) * PW'(diff2);
		rnd       = prod + HALF;
		step_full = rnd >>> GAIN_FRACTION_BITS;
		step_c    = step_full[CW-1:0];

		// per-tick rate limit
		ms_x   = CW'(cfg.max_step);
		step_l = step_c;
		if (cfg.max_step != '0) begin
			if (step_c < -ms_x) begin
				step_l = -ms_x;
			end else if (step_c > ms_x) begin
				step_l = ms_x;
			end
		end

		// saturate to the data range
		sum = (CW + 1)'(last_x) + (CW + 1)'(step_l);
		if (sum > DMAX) begin
			sum = DMAX;
		end else if (sum < DMIN) begin
			sum = DMIN;
		end
		next = sum[DATA_WIDTH-1:0];
	end

endmodule

`default_nettype wire

/* design/curvature_command_smoother_top.sv */
// top level of the curvature command smoother
// usage:
//   input channel (in_valid/in_ready) carries one word per control tick:
//   a signed target curvature and a restart flag that zeroes the stored
//   curvature before the word is processed
//   output channel (out_valid/out_ready) returns exactly one smoothed word
//   for every input word, in order
//   registers are written through cfg_we/cfg_index/cfg_wdata while idle;
//   writes to indexes above the register list are dropped
// timing:
//   a word sits in the input register, the whole update runs through one
//   multiplier and a few clamps, and lands in the result register when that
//   register is free or being emptied, which raises out_valid
//   one word per cycle sustained while out_ready stays high; the stored
//   curvature feeds back through the multiplier and the clamps around it
// reset: registers go to their defaults, stored curvature to zero (centred)
// stall: while out_ready is low the result register holds, the input
//   register fills, and in_ready drops only when both are occupied
`default_nettype none

module curvature_command_smoother_top #(
	parameter int DATA_WIDTH         = 16,
	parameter int GAIN_FRACTION_BITS = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [ccs_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  wire logic [ccs_pkg::CFG_DATA_WIDTH-1:0]     cfg_wdata,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [DATA_WIDTH-1:0]           target,
	input  wire logic                                   restart,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [DATA_WIDTH-1:0]                smoothed
);

	ccs_pkg::cfg_t cfg_q;

	logic                         valid_s1;
	logic signed [DATA_WIDTH-1:0] target_s1;
	logic                         restart_s1;
	logic                         valid_s2;
	logic signed [DATA_WIDTH-1:0] smoothed_s2;
	logic signed [DATA_WIDTH-1:0] last_q;
	logic signed [DATA_WIDTH-1:0] next;
	logic                         advance;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tracking_limit     <= ccs_pkg::TRACKING_LIMIT_RST;
			cfg_q.inverse_min_radius <= ccs_pkg::INVERSE_MIN_RADIUS_RST;
			cfg_q.deadband           <= ccs_pkg::DEADBAND_RST;
			cfg_q.filter_gain        <= ccs_pkg::FILTER_GAIN_RST;
			cfg_q.max_step           <= ccs_pkg::MAX_STEP_RST;
		end else if (cfg_we) begin
			unique case (ccs_pkg::reg_idx_t'(cfg_index))
				ccs_pkg::REG_TRACKING_LIMIT: begin
					cfg_q.tracking_limit <= cfg_wdata[ccs_pkg::LIMIT_WIDTH-1:0];
				end
				ccs_pkg::REG_INVERSE_MIN_RADIUS: begin
					cfg_q.inverse_min_radius <= cfg_wdata[ccs_pkg::LIMIT_WIDTH-1:0];
				end
				ccs_pkg::REG_DEADBAND: begin
					cfg_q.deadband <= cfg_wdata[ccs_pkg::LIMIT_WIDTH-1:0];
				end
				ccs_pkg::REG_FILTER_GAIN: begin
					cfg_q.filter_gain <= cfg_wdata[ccs_pkg::GAIN_WIDTH-1:0];
				end
				ccs_pkg::REG_MAX_STEP: begin
					cfg_q.max_step <= cfg_wdata[ccs_pkg::STEP_WIDTH-1:0];
				end
				default: begin
					// unknown index, word dropped
				end
			endcase
		end
	end

	// result slot free or being emptied this cycle
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			target_s1  <= target;
			restart_s1 <= restart;
		end
	end

	ccs_datapath #(
		.DATA_WIDTH         (DATA_WIDTH),
		.GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
	) u_datapath (
		.cfg     (cfg_q),
		.target  (target_s1),
		.restart (restart_s1),
		.last    (last_q),
		.next    (next)
	);

	// stored curvature moves only when a word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (advance) begin
			last_q <= next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			smoothed_s2 <= next;
		end
	end

	assign out_valid = valid_s2;
	assign smoothed  = smoothed_s2;

endmodule

`default_nettype wire
